/* hdl/mtp_pkg.sv */
// ----------------------------------------------------------------------------
// mtp_pkg: shared definitions for the Mersenne Twister generator
// Table geometry, recurrence constants, request kinds and seeder types.
// ----------------------------------------------------------------------------
package mtp_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned IDX_W         = $clog2(TABLE_DEPTH);
  localparam int unsigned WORD_W        = 32;

  // Recurrence and tempering constants
  localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT  = 32'h80000000;
  localparam logic [WORD_W-1:0] LOW_BITS  = 32'h7fffffff;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc60000;

  // Request kinds carried on tuser
  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // Seeder sequencer states
  typedef enum logic {
    SEED_IDLE,
    SEED_FILL
  } seed_state_e;

  // Seeder control towards the cell row
  typedef struct packed {
    logic busy;   // fill in progress, no new request taken
    logic shift;  // advance the cell row this cycle
  } seed_ctl_t;

endpackage

/* hdl/mtp_cell.sv */
// ----------------------------------------------------------------------------
// mtp_cell: one word of the state table
// Holds one 32-bit word and loads its neighbour's word when the row advances.
// ----------------------------------------------------------------------------
module mtp_cell (
  input  logic                             clk_i,
  input  logic                             shift_i,
  input  logic [mtp_pkg::WORD_W-1:0]       d_i,
  output logic [mtp_pkg::WORD_W-1:0]       q_o
);

  logic [mtp_pkg::WORD_W-1:0] word_q;

  // Take the neighbour's word on each advance
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

/* hdl/mtp_seeder.sv */
// ----------------------------------------------------------------------------
// mtp_seeder: table fill sequencer
// Pushes the seed, then one initialisation word per cycle, into the row tail.
// ----------------------------------------------------------------------------
module mtp_seeder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mtp_pkg::WORD_W-1:0]   seed_i,
  input  logic [mtp_pkg::WORD_W-1:0]   prev_i,
  output mtp_pkg::seed_ctl_t           ctl_o,
  output logic                         done_o,
  output logic [mtp_pkg::WORD_W-1:0]   feed_o
);

  mtp_pkg::seed_state_e              state_q, state_d;
  logic [mtp_pkg::IDX_W-1:0]         count_q, count_d;
  logic [mtp_pkg::WORD_W-1:0]        mixed;
  logic [mtp_pkg::WORD_W-1:0]        prod;

  localparam logic [mtp_pkg::IDX_W-1:0] LAST_IDX =
    mtp_pkg::IDX_W'(mtp_pkg::TABLE_DEPTH - 1);

  // Initialisation recurrence on the most recently pushed word
  always_comb begin
    mixed  = prev_i ^ (prev_i >> 30);
    prod   = mtp_pkg::INIT_MULT * mixed;
    feed_o = start_i ? seed_i
                     : prod + {{(mtp_pkg::WORD_W - mtp_pkg::IDX_W){1'b0}}, count_q};
  end

  // Sequencer state and word counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtp_pkg::SEED_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Next state: run the fill until the last table word is pushed
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    done_o      = 1'b0;
    ctl_o.busy  = 1'b0;
    ctl_o.shift = 1'b0;
    case (state_q)
      mtp_pkg::SEED_IDLE: begin
        if (start_i) begin
          ctl_o.shift = 1'b1;
          count_d     = mtp_pkg::IDX_W'(1);
          state_d     = mtp_pkg::SEED_FILL;
        end
      end
      mtp_pkg::SEED_FILL: begin
        ctl_o.busy  = 1'b1;
        ctl_o.shift = 1'b1;
        count_d     = count_q + mtp_pkg::IDX_W'(1);
        if (count_q == LAST_IDX) begin
          done_o  = 1'b1;
          state_d = mtp_pkg::SEED_IDLE;
        end
      end
      default: begin
        state_d = mtp_pkg::SEED_IDLE;
      end
    endcase
  end

endmodule

/* hdl/mtp_twist.sv */
// ----------------------------------------------------------------------------
// mtp_twist: twist and temper datapath
// Forms the next table word from the row head taps and tempers it for output.
// ----------------------------------------------------------------------------
module mtp_twist (
  input  logic [mtp_pkg::WORD_W-1:0] head_i,
  input  logic [mtp_pkg::WORD_W-1:0] next_i,
  input  logic [mtp_pkg::WORD_W-1:0] mid_i,
  output logic [mtp_pkg::WORD_W-1:0] word_o,
  output logic [mtp_pkg::WORD_W-1:0] tempered_o
);

  logic [mtp_pkg::WORD_W-1:0] y;
  logic [mtp_pkg::WORD_W-1:0] t1;
  logic [mtp_pkg::WORD_W-1:0] t2;
  logic [mtp_pkg::WORD_W-1:0] t3;

  // Twist: upper bit of head, lower bits of its neighbour
  always_comb begin
    y      = (head_i & mtp_pkg::HIGH_BIT) | (next_i & mtp_pkg::LOW_BITS);
    word_o = mid_i ^ (y >> 1) ^ (y[0] ? mtp_pkg::TWIST_XOR : '0);
  end

  // Temper the new word
  always_comb begin
    t1         = word_o ^ (word_o >> 11);
    t2         = t1 ^ ((t1 << 7) & mtp_pkg::TEMPER_B);
    t3         = t2 ^ ((t2 << 15) & mtp_pkg::TEMPER_C);
    tempered_o = t3 ^ (t3 >> 18);
  end

endmodule

/* hdl/mersenne_twister_prng.sv */
// A draw request's word is registered in the output stage, or in the skid stage
// while m_axis stalls. Throughput: one draw per cycle while s_axis_tready is high;
// the head of the 624-cell row is twisted and the row rotates by one word each
// seeded draw. A seed request fills the row one word per cycle through the
// multiplier in the seeder: s_axis_tready low meanwhile, no result.
// Reset clears the seeded flag and both valid bits; draws give 0 until seeded.
// ----------------------------------------------------------------------------
// mersenne_twister_prng: MT19937 word generator
// The state table is a rotating row of word cells; the head sits at the
// current draw position and the twisted word enters at the tail.
// ----------------------------------------------------------------------------
module mersenne_twister_prng (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] random_word
  output logic        m_axis_tuser    // [0] was_seeded
);

  localparam int unsigned W = mtp_pkg::WORD_W;
  localparam int unsigned D = mtp_pkg::TABLE_DEPTH;

  logic [W-1:0]        cell_q [D];
  logic [W-1:0]        feed;
  logic [W-1:0]        seed_feed;
  logic [W-1:0]        twist_word;
  logic [W-1:0]        tempered;
  logic                row_shift;
  logic                accept;
  logic                seed_start;
  logic                draw_acc;
  logic                seed_done;
  logic                seeded_q;
  mtp_pkg::seed_ctl_t  seed_ctl;

  logic                res_valid;
  logic [W-1:0]        res_word;
  logic                out_valid_q;
  logic [W-1:0]        out_word_q;
  logic                out_flag_q;
  logic                skid_valid_q;
  logic [W-1:0]        skid_word_q;
  logic                skid_flag_q;

  // Request acceptance
  assign s_axis_tready = !seed_ctl.busy && !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign seed_start    = accept && (s_axis_tuser == mtp_pkg::REQ_SEED);
  assign draw_acc      = accept && (s_axis_tuser == mtp_pkg::REQ_DRAW);

  mtp_seeder u_seeder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seed_start),
    .seed_i  (s_axis_tdata),
    .prev_i  (cell_q[D-1]),
    .ctl_o   (seed_ctl),
    .done_o  (seed_done),
    .feed_o  (seed_feed)
  );

  mtp_twist u_twist (
    .head_i     (cell_q[0]),
    .next_i     (cell_q[1]),
    .mid_i      (cell_q[mtp_pkg::MIDDLE_OFFSET]),
    .word_o     (twist_word),
    .tempered_o (tempered)
  );

  // Advance the row on every fill step and on every seeded draw
  assign row_shift = seed_ctl.shift || (draw_acc && seeded_q);
  assign feed      = seed_ctl.shift ? seed_feed : twist_word;

  for (genvar k = 0; k < D; k++) begin : g_cell
    if (k == D - 1) begin : g_tail
      mtp_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (row_shift),
        .d_i     (feed),
        .q_o     (cell_q[k])
      );
    end else begin : g_body
      mtp_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (row_shift),
        .d_i     (cell_q[k+1]),
        .q_o     (cell_q[k])
      );
    end
  end

  // Seeded flag: set once the fill completes, kept across reseeds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
    end else if (seed_done) begin
      seeded_q <= 1'b1;
    end
  end

  // Draw result
  assign res_valid = draw_acc;
  assign res_word  = seeded_q ? tempered : '0;

  // Output register with skid stage: valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output register with skid stage: payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_word_q <= skid_word_q;
        out_flag_q <= skid_flag_q;
      end else begin
        out_word_q <= res_word;
        out_flag_q <= seeded_q;
      end
    end else if (res_valid) begin
      skid_word_q <= res_word;
      skid_flag_q <= seeded_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_flag_q;

endmodule

/* hdl/mtp_checker.sv */
// ----------------------------------------------------------------------------
// mtp_checker: port-level checks for the generator
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module mtp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Unseeded draws give zero
  a_unseeded_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("unseeded draw gave a non-zero word");

  // A seed request blocks further requests while the table fills
  a_seed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == mtp_pkg::REQ_SEED)
    |=> !s_axis_tready)
    else $error("request taken during table fill");

  // A result appears only after a draw request
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == mtp_pkg::REQ_DRAW)))
    else $error("result without a draw request");

endmodule

bind mersenne_twister_prng mtp_checker u_mtp_checker (.*);

/* verif/mt_draw_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mt_draw_checker: word predictor and comparator for the MT19937 generator
// Watches both stream channels, keeps its own copy of the 624-word table,
// the draw position and the seeded flag, and queues the word (tempered, or zero
// before seeding) each accepted draw should give. Returned words are compared in
// order, field by field. Seed, draw, cold-draw and mismatch counts go to the top.
// ----------------------------------------------------------------------------
module mt_draw_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
  input  logic        s_axis_tuser,   // [0] req_type
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] random_word
  input  logic        m_axis_tuser,   // [0] was_seeded
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned seed_count_o,
  output int unsigned draw_count_o,
  output int unsigned cold_draw_count_o
);

  typedef struct packed {
    logic [mtp_pkg::WORD_W-1:0] word;
    logic                       seeded;
  } draw_word_t;

  // Predicted generator state
  logic [mtp_pkg::WORD_W-1:0] mt_table [mtp_pkg::TABLE_DEPTH];
  int unsigned                mt_pos    = 0;
  logic                       mt_seeded = 1'b0;

  // Words still owed by the block, oldest first
  draw_word_t expected_draws[$];

  initial begin
    error_count_o     = 0;
    pending_o         = 0;
    seed_count_o      = 0;
    draw_count_o      = 0;
    cold_draw_count_o = 0;
  end

  // Fill the whole table from one seed word
  function automatic void refill_table(input logic [mtp_pkg::WORD_W-1:0] seed);
    logic [mtp_pkg::WORD_W-1:0] prev;
    mt_table[0] = seed;
    for (int k = 1; k < mtp_pkg::TABLE_DEPTH; k++) begin
      prev        = mt_table[k-1];
      mt_table[k] = mtp_pkg::INIT_MULT * (prev ^ (prev >> 30)) + mtp_pkg::WORD_W'(k);
    end
  endfunction

  // Twist the word at the draw position and advance the position
  function automatic logic [mtp_pkg::WORD_W-1:0] twist_word();
    int unsigned                nxt;
    int unsigned                mid;
    logic [mtp_pkg::WORD_W-1:0] y;
    logic [mtp_pkg::WORD_W-1:0] w;
    nxt = (mt_pos + 1) % mtp_pkg::TABLE_DEPTH;
    mid = (mt_pos + mtp_pkg::MIDDLE_OFFSET) % mtp_pkg::TABLE_DEPTH;
    y   = (mt_table[mt_pos] & mtp_pkg::HIGH_BIT) | (mt_table[nxt] & mtp_pkg::LOW_BITS);
    w   = mt_table[mid] ^ (y >> 1) ^ (y[0] ? mtp_pkg::TWIST_XOR : '0);
    mt_table[mt_pos] = w;
    mt_pos = nxt;
    return w;
  endfunction

  function automatic logic [mtp_pkg::WORD_W-1:0] temper_word(
    input logic [mtp_pkg::WORD_W-1:0] raw
  );
    logic [mtp_pkg::WORD_W-1:0] y;
    y = raw;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtp_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtp_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Print one mismatch line (capped) and count it
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count_o < 50) begin
      $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    end
    error_count_o++;
  endtask

  // Predict on every accepted request, compare every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    draw_word_t want;
    if (!rst_ni) begin
      expected_draws.delete();
      mt_pos    = 0;
      mt_seeded = 1'b0;
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == mtp_pkg::REQ_SEED) begin
          refill_table(s_axis_tdata);
          mt_pos    = 0;
          mt_seeded = 1'b1;
          seed_count_o++;
        end else if (!mt_seeded) begin
          // unseeded draw: no table access, word is zero
          expected_draws.push_back('{word: '0, seeded: 1'b0});
          cold_draw_count_o++;
        end else begin
          expected_draws.push_back('{word: temper_word(twist_word()), seeded: 1'b1});
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        draw_count_o++;
        if (expected_draws.size() == 0) begin
          report_mismatch("word with no draw outstanding", m_axis_tdata, '0);
        end else begin
          want = expected_draws.pop_front();
          if (m_axis_tdata !== want.word) begin
            report_mismatch("random_word", m_axis_tdata, want.word);
          end
          if (m_axis_tuser !== want.seeded) begin
            report_mismatch("was_seeded", 32'(m_axis_tuser), 32'(want.seeded));
          end
        end
      end
      pending_o <= expected_draws.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the MT19937 generator
// Sends a short directed run (unseeded draws, extreme and standard seeds,
// back-to-back reseeds) followed by random draws with occasional reseeds,
// including a long draw run that wraps the table. Both channels stall at
// random; the checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RANDOM_ITEMS = 1880;
  localparam int unsigned STALL_LIMIT  = 5000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = mtp_pkg::REQ_DRAW;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic        calm = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count;
  int unsigned pending;
  int unsigned seed_count;
  int unsigned draw_count;
  int unsigned cold_draw_count;

  always #10 clk_i = ~clk_i;

  mersenne_twister_prng dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mt_draw_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .error_count_o     (error_count),
    .pending_o         (pending),
    .seed_count_o      (seed_count),
    .draw_count_o      (draw_count),
    .cold_draw_count_o (cold_draw_count)
  );

  // Stall the result side now and then, never during the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 9);
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no request or word moved for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, hold it until taken, then maybe idle a little
  task automatic push_request(input logic kind, input logic [31:0] seed);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= seed;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 20);
    end
  endtask

  // Drop valid and wait until every outstanding word has come back
  task automatic drain_draws();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int unsigned n;
    logic        kind;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // draws before any seed give zero
    push_request(mtp_pkg::REQ_DRAW, '0);
    push_request(mtp_pkg::REQ_DRAW, '1);
    push_request(mtp_pkg::REQ_DRAW, $urandom());
    // extreme seeds
    push_request(mtp_pkg::REQ_SEED, '0);
    repeat (3) push_request(mtp_pkg::REQ_DRAW, $urandom());
    push_request(mtp_pkg::REQ_SEED, '1);
    repeat (3) push_request(mtp_pkg::REQ_DRAW, $urandom());
    // the customary default seed
    push_request(mtp_pkg::REQ_SEED, 32'd5489);
    repeat (5) push_request(mtp_pkg::REQ_DRAW, $urandom());
    // reseed straight after a reseed
    push_request(mtp_pkg::REQ_SEED, $urandom());
    push_request(mtp_pkg::REQ_SEED, $urandom());
    repeat (3) push_request(mtp_pkg::REQ_DRAW, $urandom());

    // hold the sender until the result side has caught up
    drain_draws();

    // random part: a long unbroken draw run first so the table wraps
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 900) && (n < 1300);
      kind = (n >= 700 && $urandom_range(149) == 0) ? mtp_pkg::REQ_SEED
                                                    : mtp_pkg::REQ_DRAW;
      push_request(kind, $urandom());
    end

    drain_draws();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d seed requests and %0d returned words (%0d before seeding),",
             seed_count, draw_count, cold_draw_count);
    $display("with reseeds, extreme seeds, table wrap-around and stalls on both sides.");
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
